FILE: hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and constants of the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POSITION_W = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned RESULT_W   = STATUS_W + 1 + POSITION_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } sle_opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } sle_status_e;

  // per-cycle update command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rm;
    logic clr;
  } sle_cmd_t;

endpackage

FILE: hdl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// one list slot: compares its entry with the key and shifts with neighbors
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int unsigned KeyW   = 32,
  parameter bit          IsHead = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sle_pkg::sle_cmd_t cmd_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [KeyW-1:0]  left_entry_i,
  input  logic             left_valid_i,
  input  logic             left_ge_i,
  input  logic [KeyW-1:0]  right_entry_i,
  input  logic             right_valid_i,
  output logic [KeyW-1:0]  entry_o,
  output logic             valid_o,
  output logic             eq_o,
  output logic             ge_o
);
  import sle_pkg::*;

  logic [KeyW-1:0] entry_q, entry_d;
  logic            valid_q, valid_d;
  logic            lt, eq, ge;

  assign lt = valid_q && (entry_q < key_i);
  assign eq = valid_q && (entry_q == key_i);
  // an insert equal to the head entry lands behind it
  assign ge = IsHead ? (!lt && !eq) : !lt;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (cmd_i.ins && ge) begin
      if (!left_ge_i) begin
        entry_d = key_i;
        valid_d = 1'b1;
      end else begin
        entry_d = left_entry_i;
        valid_d = left_valid_i;
      end
    end else if (cmd_i.rm && !lt) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign eq_o    = eq;
  assign ge_o    = ge;

endmodule

FILE: hdl/sle_index_enc.sv
// ----------------------------------------------------------------------------
// sle_index_enc
// one-hot to binary index encoder over the cell row
// ----------------------------------------------------------------------------
module sle_index_enc #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0]         hot_i,
  output logic [$clog2(N)-1:0] idx_o
);
  import sle_pkg::*;

  localparam int unsigned IdxW = $clog2(N);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < N; i++) begin
      if (hot_i[i]) begin
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

endmodule

FILE: hdl/sorted_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// ascending multiset of signed values held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// All cells compare their entry with the value at
// once, and on insert or remove each cell loads from its left or right
// neighbor in the same edge, so a new word is accepted every cycle as long as
// the result register is free or drained. Each word yields one result word.
// Values are kept as offset-binary keys so unsigned compare gives signed order.
module sorted_list_engine_core #(
  parameter int unsigned CAPACITY    = sle_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = sle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // opcode, value
  input  logic [((sle_pkg::OPCODE_W+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // status, found, position, entry_count
  output logic [sle_pkg::OUT_DATA_W-1:0]              m_axis_tdata_o
);
  import sle_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  sle_opcode_e            opcode;
  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] key;
  logic                   accept;

  logic [CntW-1:0] occ_q, occ_d;
  logic            full;

  logic [VALUE_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]    valid, eq, ge;
  logic [CAPACITY-1:0]    ins_hot, eq_hot;
  logic [IdxW-1:0]        ins_idx, eq_idx;
  logic                   found_any;
  sle_cmd_t               cmd;

  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  sle_status_e            status;
  logic                   found;
  logic [IdxW-1:0]        pos;
  logic [RESULT_W-1:0]    result;

  assign opcode = sle_opcode_e'(s_axis_tdata_i[OPCODE_W-1:0]);
  assign value  = s_axis_tdata_i[OPCODE_W +: VALUE_WIDTH];
  assign key    = {~value[VALUE_WIDTH-1], value[VALUE_WIDTH-2:0]};

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (occ_q == CntW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_entry, right_entry;
    logic                   left_valid, left_ge, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_ge    = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_valid = valid[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
      assign right_valid = valid[i+1];
    end

    sle_cell #(
      .KeyW   (VALUE_WIDTH),
      .IsHead (i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .key_i         (key),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .left_ge_i     (left_ge),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .entry_o       (entry[i]),
      .valid_o       (valid[i]),
      .eq_o          (eq[i]),
      .ge_o          (ge[i])
    );

    assign ins_hot[i] = ge[i] && !left_ge;
    if (i == 0) begin : g_eq_head
      assign eq_hot[i] = eq[i];
    end else begin : g_eq_body
      assign eq_hot[i] = eq[i] && !eq[i-1];
    end
  end

  sle_index_enc #(.N(CAPACITY)) u_ins_enc (
    .hot_i (ins_hot),
    .idx_o (ins_idx)
  );

  sle_index_enc #(.N(CAPACITY)) u_eq_enc (
    .hot_i (eq_hot),
    .idx_o (eq_idx)
  );

  assign found_any = |eq;

  always_comb begin
    cmd    = '0;
    occ_d  = occ_q;
    status = ST_OK;
    found  = 1'b0;
    pos    = '0;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = accept;
          occ_d   = occ_q + CntW'(1);
          pos     = ins_idx;
        end
      end
      OP_REMOVE: begin
        if (found_any) begin
          cmd.rm = accept;
          occ_d  = occ_q - CntW'(1);
          found  = 1'b1;
          pos    = eq_idx;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (found_any) begin
          found = 1'b1;
          pos   = eq_idx;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        cmd.clr = accept;
        occ_d   = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign result = {COUNT_W'(occ_d), POSITION_W'(pos), found, status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= OUT_DATA_W'(result);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: sim/tb_sorted_list_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_engine_core
// self-checking bench for the sorted list engine core
// ----------------------------------------------------------------------------
// A table of directed words hits the empty, full, equal-value and extreme-value
// cases, then phases of random words run with different operation mixes,
// bursty input and patterned output stalls. Every accepted input word runs
// through a local model of the list, and every result word is compared field
// by field with the oldest predicted result.
module tb_sorted_list_engine_core;
  import sle_pkg::*;

  localparam int unsigned IN_W      = ((OPCODE_W + VALUE_WIDTH_DEF + 7) / 8) * 8;
  localparam int unsigned DEPTH     = CAPACITY_DEF;
  localparam int unsigned IDLE_MAX  = 2000;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned PHASE_LEN = 100;
  localparam int unsigned N_DIR     = 25;

  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    logic [POSITION_W-1:0] pos;
    logic                  found;
    sle_status_e           status;
  } list_result_t;

  typedef struct {
    sle_opcode_e  op;
    logic [31:0]  value;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  typedef struct {
    bit           typed;
    list_result_t res;
  } word_tag_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_W-1:0]       s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // model of the list
  logic signed [31:0] list_ent [DEPTH];
  int unsigned        list_occ = 0;

  list_result_t result_q [$];
  word_tag_t    word_tag_q [$];
  int unsigned  err_cnt = 0;
  int unsigned  idle_cnt = 0;

  // sender and receiver shaping
  int unsigned gap_max = 0;
  int unsigned burst_max = 1;
  int unsigned burst_left = 0;
  logic [15:0] rx_pattern = 16'hffff;
  int unsigned rx_idx = 0;

  dir_row_t dir_rows [N_DIR];

  sorted_list_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic predict_list_op(input sle_opcode_e op, input logic signed [31:0] val,
                                 output list_result_t res);
    int unsigned pos;
    int unsigned less;
    bit          hit;
    pos = 0;
    hit = 1'b0;
    res = '0;
    case (op)
      OP_INSERT: begin
        if (list_occ >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (list_occ == 0 || val < list_ent[0]) begin
            pos = 0;
          end else begin
            less = 0;
            for (int i = 0; i < list_occ; i++) begin
              if (list_ent[i] < val) less++;
            end
            pos = (less < 1) ? 1 : less;
          end
          for (int i = list_occ; i > pos; i--) list_ent[i] = list_ent[i-1];
          list_ent[pos] = val;
          list_occ++;
          res.status = ST_OK;
          res.pos = pos[POSITION_W-1:0];
        end
      end
      OP_REMOVE, OP_FIND: begin
        for (int i = 0; i < list_occ; i++) begin
          if (!hit && list_ent[i] == val) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          if (op == OP_REMOVE) begin
            for (int i = pos; i + 1 < list_occ; i++) list_ent[i] = list_ent[i+1];
            list_occ--;
          end
          res.status = ST_OK;
          res.found = 1'b1;
          res.pos = pos[POSITION_W-1:0];
        end
      end
      default: begin
        list_occ = 0;
        res.status = ST_OK;
      end
    endcase
    res.count = list_occ[COUNT_W-1:0];
  endtask

  function automatic dir_row_t mk_row(sle_opcode_e op, logic [31:0] value, bit typed,
                                      sle_status_e st, logic found, int unsigned pos,
                                      int unsigned count);
    dir_row_t r;
    r.op = op;
    r.value = value;
    r.typed = typed;
    r.res.status = st;
    r.res.found = found;
    r.res.pos = pos[POSITION_W-1:0];
    r.res.count = count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = $urandom_range(0, 15) - 32'd8;
    end else if (r < 70 && list_occ > 0) begin
      v = list_ent[$urandom_range(0, list_occ - 1)];
    end else if (r < 82) begin
      case ($urandom_range(0, 5))
        0: v = 32'h8000_0000;
        1: v = 32'h8000_0001;
        2: v = 32'h7fff_ffff;
        3: v = 32'h7fff_fffe;
        4: v = 32'hffff_ffff;
        default: v = 32'h0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // called in the step of the previous acceptance, returns at this word's acceptance
  task automatic send_word(input sle_opcode_e op, input logic [31:0] value, input bit typed,
                           input list_result_t res);
    int unsigned gap;
    word_tag_t   tag;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    tag.typed = typed;
    tag.res = res;
    word_tag_q.push_back(tag);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(IN_W - OPCODE_W - 32){1'b0}}, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (result_q.size() != 0 || word_tag_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    m_axis_tready_i <= rx_pattern[rx_idx];
    rx_idx <= (rx_idx + 1) % 16;
  end

  // prediction and checking
  always @(posedge clk_i) begin
    word_tag_t    tag;
    list_result_t want;
    list_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tag = word_tag_q.pop_front();
        predict_list_op(sle_opcode_e'(s_axis_tdata_i[OPCODE_W-1:0]),
                        s_axis_tdata_i[OPCODE_W +: 32], want);
        if (tag.typed) want = tag.res;
        result_q.push_back(want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = list_result_t'(m_axis_tdata_o[RESULT_W-1:0]);
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_cnt++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            err_cnt++;
          end
          if (got.pos !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, got.pos);
            err_cnt++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
    begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    list_result_t none;
    int unsigned  r;
    int unsigned  ins_pct;
    int unsigned  rm_pct;
    int unsigned  find_pct;
    sle_opcode_e  op;
    none = '0;
    for (int i = 0; i < DEPTH; i++) list_ent[i] = '0;

    dir_rows[0]  = mk_row(OP_FIND,   32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0);
    dir_rows[1]  = mk_row(OP_REMOVE, 32'hffff_ffff, 1, ST_NOT_FOUND, 0, 0, 0);
    dir_rows[2]  = mk_row(OP_INSERT, 32'h7fff_ffff, 1, ST_OK,        0, 0, 1);
    dir_rows[3]  = mk_row(OP_INSERT, 32'h8000_0000, 1, ST_OK,        0, 0, 2);
    dir_rows[4]  = mk_row(OP_INSERT, 32'h8000_0000, 1, ST_OK,        0, 1, 3);
    dir_rows[5]  = mk_row(OP_INSERT, 32'h0000_0000, 0, ST_OK,        0, 0, 0);
    dir_rows[6]  = mk_row(OP_INSERT, 32'h7fff_ffff, 0, ST_OK,        0, 0, 0);
    dir_rows[7]  = mk_row(OP_INSERT, 32'h0000_0000, 0, ST_OK,        0, 0, 0);
    dir_rows[8]  = mk_row(OP_INSERT, 32'hffff_ffff, 0, ST_OK,        0, 0, 0);
    dir_rows[9]  = mk_row(OP_INSERT, 32'h0000_0001, 0, ST_OK,        0, 0, 0);
    dir_rows[10] = mk_row(OP_INSERT, 32'h5555_5555, 0, ST_OK,        0, 0, 0);
    dir_rows[11] = mk_row(OP_INSERT, 32'haaaa_aaaa, 0, ST_OK,        0, 0, 0);
    dir_rows[12] = mk_row(OP_INSERT, 32'h8000_0001, 0, ST_OK,        0, 0, 0);
    dir_rows[13] = mk_row(OP_INSERT, 32'h7fff_fffe, 0, ST_OK,        0, 0, 0);
    dir_rows[14] = mk_row(OP_INSERT, 32'h0000_0002, 0, ST_OK,        0, 0, 0);
    dir_rows[15] = mk_row(OP_INSERT, 32'h0000_0003, 0, ST_OK,        0, 0, 0);
    dir_rows[16] = mk_row(OP_INSERT, 32'h0000_0004, 0, ST_OK,        0, 0, 0);
    dir_rows[17] = mk_row(OP_INSERT, 32'h0000_0005, 0, ST_OK,        0, 0, 0);
    dir_rows[18] = mk_row(OP_INSERT, 32'h0000_0006, 1, ST_FULL,      0, 0, 16);
    dir_rows[19] = mk_row(OP_FIND,   32'h7fff_ffff, 0, ST_OK,        0, 0, 0);
    dir_rows[20] = mk_row(OP_REMOVE, 32'h7fff_ffff, 0, ST_OK,        0, 0, 0);
    dir_rows[21] = mk_row(OP_REMOVE, 32'h0000_3039, 0, ST_OK,        0, 0, 0);
    dir_rows[22] = mk_row(OP_FIND,   32'h8000_0000, 0, ST_OK,        0, 0, 0);
    dir_rows[23] = mk_row(OP_CLEAR,  32'hdead_beef, 1, ST_OK,        0, 0, 0);
    dir_rows[24] = mk_row(OP_FIND,   32'h0000_0000, 1, ST_NOT_FOUND, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
    end
    drain_results();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) begin
        gap_max = 0;
        burst_max = 1;
        rx_pattern = 16'hffff;
      end else begin
        gap_max = $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
        burst_max = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
          0: rx_pattern = 16'hffff;
          1: rx_pattern = 16'($urandom) | 16'h0001;
          default: rx_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      case (ph % 3)
        0: begin ins_pct = 60; rm_pct = 15; find_pct = 23; end
        1: begin ins_pct = 30; rm_pct = 45; find_pct = 23; end
        default: begin ins_pct = 40; rm_pct = 25; find_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + rm_pct) op = OP_REMOVE;
        else if (r < ins_pct + rm_pct + find_pct) op = OP_FIND;
        else op = OP_CLEAR;
        send_word(op, pick_value(), 0, none);
      end
      // hold off until everything in flight has come back
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sle_index_enc.sv
hdl/sorted_list_engine_core.sv
sim/tb_sorted_list_engine_core.sv
